// ----- design/debounced_pulse_counter_overspeed_top_defines.svh -----
`ifndef DEBOUNCED_PULSE_COUNTER_OVERSPEED_TOP_DEFINES_SVH
`define DEBOUNCED_PULSE_COUNTER_OVERSPEED_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DPCO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DPCO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dpco_pkg.sv -----
package dpco_pkg;

  localparam int CNT_W   = 32;
  localparam int MASK_W  = 16;
  localparam int LIMIT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALT_LIMIT    = 2'd2;

  localparam logic [MASK_W-1:0]  RST_DEBOUNCE_MASK = 16'd15;
  localparam logic [CNT_W-1:0]   RST_HALT_INTERVAL = 32'd60;
  localparam logic [LIMIT_W-1:0] RST_HALT_LIMIT    = 16'd10;

  typedef struct packed {
    logic pin_level;
    logic arm_check;
  } in_item_t;

  typedef struct packed {
    logic             pulse_detected;
    logic [CNT_W-1:0] pulse_count;
    logic [CNT_W-1:0] overspeed_events;
    logic             halt_active;
    logic             check_armed;
  } out_item_t;

  // classified tick passed from front to back
  typedef struct packed {
    logic pulse;
    logic arm;
  } cls_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic halt;
    logic armed;
  } back_stat_t;

endpackage

// ----- design/dpco_front.sv -----
module dpco_front
  import dpco_pkg::*;
#(
  parameter int HISTORY_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  in_item_t          item,
  input  logic [MASK_W-1:0] mask,
  output cls_item_t         cls
);

  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  logic                    low_r, low_nxt;
  logic [HISTORY_BITS-1:0] mask_h;
  logic [HISTORY_BITS-1:0] sel;
  logic                    mask_hi_nz;
  logic                    sel_zero, sel_full, low_after;

  assign mask_h     = HISTORY_BITS'(mask);
  assign mask_hi_nz = |(mask >> HISTORY_BITS);
  assign hist_nxt   = {hist_r[HISTORY_BITS-2:0], item.pin_level};
  assign sel        = hist_nxt & mask_h;
  assign sel_zero   = (sel == '0);
  // mask bits beyond the history never match a one
  assign sel_full   = (sel == mask_h) && !mask_hi_nz;
  assign low_after  = low_r | sel_zero;

  always_comb begin
    cls.pulse = low_after & sel_full;
    cls.arm   = item.arm_check;
    low_nxt   = low_after & ~cls.pulse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      low_r  <= 1'b0;
    end else if (acc) begin
      hist_r <= hist_nxt;
      low_r  <= low_nxt;
    end
  end

endmodule

// ----- design/dpco_queue.sv -----
module dpco_queue
  import dpco_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t wr_item,
  input  logic      pop,
  output cls_item_t rd_item,
  output q_stat_t   stat
);

  cls_item_t  mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign rd_item    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/dpco_back.sv -----
module dpco_back
  import dpco_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cls_item_t          cls,
  output logic               pop,
  input  logic [CNT_W-1:0]   lim_ticks,
  input  logic [LIMIT_W-1:0] lim_count,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  output back_stat_t         stat
);

  logic [CNT_W-1:0] interval_r, interval_nxt;
  logic [CNT_W-1:0] pulse_r, pulse_nxt;
  logic [CNT_W-1:0] ovs_r, ovs_nxt;
  logic             armed_r, armed_nxt;
  logic             halt_r, halt_nxt;
  logic             ovalid_r, ovalid_nxt;
  out_item_t        odata_r, odata_nxt;
  logic [CNT_W-1:0] iv_inc, ovs_inc;
  logic             armed_a, ovs_hit, halt_hit;

  assign pop = !q_empty && (!ovalid_r || !out_stall);

  always_comb begin
    armed_a  = armed_r | cls.arm;
    iv_inc   = interval_r + 1'b1;
    ovs_inc  = ovs_r + 1'b1;
    ovs_hit  = cls.pulse && armed_a && (iv_inc < lim_ticks);
    halt_hit = ovs_hit && (ovs_inc >= {{(CNT_W-LIMIT_W){1'b0}}, lim_count});

    interval_nxt = cls.pulse ? '0 : iv_inc;
    pulse_nxt    = cls.pulse ? pulse_r + 1'b1 : pulse_r;
    ovs_nxt      = ovs_hit ? ovs_inc : ovs_r;
    armed_nxt    = armed_a & ~halt_hit;
    halt_nxt     = halt_r | halt_hit;

    odata_nxt.pulse_detected   = cls.pulse;
    odata_nxt.pulse_count      = pulse_nxt;
    odata_nxt.overspeed_events = ovs_nxt;
    odata_nxt.halt_active      = halt_nxt;
    odata_nxt.check_armed      = armed_nxt;

    ovalid_nxt = pop | (ovalid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      pulse_r    <= '0;
      ovs_r      <= '0;
      armed_r    <= 1'b0;
      halt_r     <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (pop) begin
        interval_r <= interval_nxt;
        pulse_r    <= pulse_nxt;
        ovs_r      <= ovs_nxt;
        armed_r    <= armed_nxt;
        halt_r     <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      odata_r <= odata_nxt;
    end
  end

  assign out_valid  = ovalid_r;
  assign out_data   = odata_r;
  assign stat.halt  = halt_r;
  assign stat.armed = armed_r;

endmodule

// ----- design/debounced_pulse_counter_overspeed_top.sv -----
// Channel  Ports                         Item
// in       in_valid/in_stall/in_data     in_item_t  (pin_level, arm_check)
// out      out_valid/out_stall/out_data  out_item_t (pulse and overspeed status)
// cfg      cfg_we/cfg_index/cfg_wdata    register write, no read-back
//
// One item per cycle while out_stall is low; results come from the output register.
// The front shifts the history and classifies the tick in the accept cycle; a
// two-entry queue feeds the back, which updates counters into the output register.
// in_stall rises only when the queue is full, i.e. after the output has stalled.
// Synchronous active-low reset; no clearing pass.
`include "debounced_pulse_counter_overspeed_top_defines.svh"

module debounced_pulse_counter_overspeed_top
  import dpco_pkg::*;
#(
  parameter int HISTORY_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [MASK_W-1:0]  mask_r;
  logic [CNT_W-1:0]   lim_ticks_r;
  logic [LIMIT_W-1:0] lim_count_r;
  logic               in_acc, pop;
  cls_item_t          cls_wr, cls_rd;
  q_stat_t            q_st;
  back_stat_t         b_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= RST_DEBOUNCE_MASK;
      lim_ticks_r <= RST_HALT_INTERVAL;
      lim_count_r <= RST_HALT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_MASK: mask_r      <= cfg_wdata[MASK_W-1:0];
        REG_HALT_INTERVAL: lim_ticks_r <= cfg_wdata[CNT_W-1:0];
        REG_HALT_LIMIT:    lim_count_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_st.full;
  assign in_acc   = in_valid && !in_stall;

  dpco_front #(
    .HISTORY_BITS(HISTORY_BITS)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (in_acc),
    .item (in_data),
    .mask (mask_r),
    .cls  (cls_wr)
  );

  dpco_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_acc),
    .wr_item(cls_wr),
    .pop    (pop),
    .rd_item(cls_rd),
    .stat   (q_st)
  );

  dpco_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_st.empty),
    .cls      (cls_rd),
    .pop      (pop),
    .lim_ticks(lim_ticks_r),
    .lim_count(lim_count_r),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .stat     (b_st)
  );

  `DPCO_ASSERT_SAME(a_no_pop_empty, pop, !q_st.empty, "pop from empty queue")
  `DPCO_ASSERT_NEXT(a_halt_sticky, b_st.halt, b_st.halt, "halt latch cleared")
  `DPCO_ASSERT_SAME(a_halt_disarms, $rose(b_st.halt), !b_st.armed, "halt without disarm")

endmodule
